// File: rtl/rtcm3_pkg.sv
// ----------------------------------------------------------------------------
// rtcm3_pkg
// Shared types, constants and the CRC-24Q byte step for the RTCM3 deframer.
// ----------------------------------------------------------------------------
package rtcm3_pkg;

  // Frame constants
  localparam logic [7:0]  Preamble  = 8'hD3;
  // Low 24 bits of 0x1864CFB; the top bit is implied by the shift-out
  localparam logic [23:0] CrcPoly   = 24'h864CFB;
  localparam logic [1:0]  LenHiMask = 2'h3;
  localparam logic [9:0]  CrcBytes  = 10'd3;

  // Deframer phase
  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  // Input word held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [11:0] message_number;
    logic [9:0]  payload_length;
    logic        crc_ok;
    logic [23:0] computed_crc;
  } result_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic    emit;
    result_t res;
  } emit_t;

  // CRC-24Q over one byte, msb first, no reflection
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc,
                                              input logic [7:0]  b);
    logic [23:0] c;
    logic        top;
    c = crc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      top = c[23];
      c   = {c[22:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/rtcm3_in_stage.sv
// ----------------------------------------------------------------------------
// rtcm3_in_stage
// Input register: holds one byte word until the parser takes it.
// ----------------------------------------------------------------------------
module rtcm3_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               take_i,
  output rtcm3_pkg::in_word_t word_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       accept;

  // Stall only when a word is held and the parser does not take it
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// File: rtl/rtcm3_parser.sv
// ----------------------------------------------------------------------------
// rtcm3_parser
// Frame state machine, CRC-24Q accumulation and message number capture.
// ----------------------------------------------------------------------------
module rtcm3_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtcm3_pkg::in_word_t word_i,
  input  logic                out_ready_i,
  output logic                take_o,
  output rtcm3_pkg::emit_t    emit_o
);

  rtcm3_pkg::phase_e phase_q, phase_d;
  logic [9:0]  count_q, count_d;
  logic [9:0]  len_q, len_d;
  logic [23:0] crc_q, crc_d;
  logic [23:0] rx_q, rx_d;
  logic [11:0] msg_q, msg_d;
  logic [7:0]  b;
  logic [23:0] crc_next;
  logic [9:0]  count_inc;
  logic        last_byte;
  logic        pos0, pos1;

  assign b         = word_i.data;
  assign crc_next  = rtcm3_pkg::crc24q_byte(crc_q, b);
  assign count_inc = count_q + 10'd1;

  // Only the last CRC byte needs room in the output register
  assign last_byte = (phase_q == rtcm3_pkg::PH_CRC) && (count_inc == rtcm3_pkg::CrcBytes);
  assign take_o    = word_i.valid && (!last_byte || out_ready_i);

  // Byte position after the header, checked for the first two positions
  always_comb begin
    pos0 = 1'b0;
    pos1 = 1'b0;
    case (phase_q)
      rtcm3_pkg::PH_PAYLOAD: begin
        pos0 = (count_q == 10'd0);
        pos1 = (count_q == 10'd1);
      end
      rtcm3_pkg::PH_CRC: begin
        pos0 = (len_q == 10'd0) && (count_q == 10'd0);
        pos1 = ((len_q == 10'd0) && (count_q == 10'd1)) ||
               ((len_q == 10'd1) && (count_q == 10'd0));
      end
      default: begin
        pos0 = 1'b0;
        pos1 = 1'b0;
      end
    endcase
  end

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    crc_d   = crc_q;
    rx_d    = rx_q;
    msg_d   = msg_q;
    emit_o  = '0;

    // message number capture (payload and CRC phases only)
    if (pos0) begin
      msg_d = {b, 4'h0};
    end else if (pos1) begin
      msg_d = {msg_q[11:4], b[7:4]};
    end

    case (phase_q)
      rtcm3_pkg::PH_LEN_HI: begin
        len_d   = {b[1:0] & rtcm3_pkg::LenHiMask, 8'h00};
        crc_d   = crc_next;
        phase_d = rtcm3_pkg::PH_LEN_LO;
      end
      rtcm3_pkg::PH_LEN_LO: begin
        len_d   = {len_q[9:8], b};
        crc_d   = crc_next;
        count_d = 10'd0;
        rx_d    = 24'h0;
        phase_d = ({len_q[9:8], b} == 10'd0) ? rtcm3_pkg::PH_CRC : rtcm3_pkg::PH_PAYLOAD;
      end
      rtcm3_pkg::PH_PAYLOAD: begin
        crc_d = crc_next;
        if (count_inc == len_q) begin
          count_d = 10'd0;
          phase_d = rtcm3_pkg::PH_CRC;
        end else begin
          count_d = count_inc;
        end
      end
      rtcm3_pkg::PH_CRC: begin
        rx_d    = {rx_q[15:0], b};
        count_d = count_inc;
        if (last_byte) begin
          emit_o.emit               = word_i.valid && take_o;
          emit_o.res.message_number = msg_d;
          emit_o.res.payload_length = len_q;
          emit_o.res.crc_ok         = (crc_q == rx_d);
          emit_o.res.computed_crc   = crc_q;
          count_d = 10'd0;
          phase_d = rtcm3_pkg::PH_SEARCH;
        end
      end
      default: begin
        // preamble search; unused codes behave the same
        if (b == rtcm3_pkg::Preamble) begin
          crc_d   = rtcm3_pkg::crc24q_byte(24'h0, b);
          len_d   = 10'd0;
          count_d = 10'd0;
          rx_d    = 24'h0;
          msg_d   = 12'h0;
          phase_d = rtcm3_pkg::PH_LEN_HI;
        end else begin
          phase_d = rtcm3_pkg::PH_SEARCH;
        end
      end
    endcase
  end

  // State registers, updated only when a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rtcm3_pkg::PH_SEARCH;
      count_q <= 10'd0;
      len_q   <= 10'd0;
      crc_q   <= 24'h0;
      rx_q    <= 24'h0;
      msg_q   <= 12'h0;
    end else if (take_o) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rx_q    <= rx_d;
      msg_q   <= msg_d;
    end
  end

  // Checks
  a_emit_returns_to_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.emit |=> phase_q == rtcm3_pkg::PH_SEARCH)
    else $error("parser did not return to preamble search after a frame");

  a_payload_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rtcm3_pkg::PH_PAYLOAD |-> count_q < len_q)
    else $error("payload count reached the frame length");

  a_crc_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rtcm3_pkg::PH_CRC |-> count_q < rtcm3_pkg::CrcBytes)
    else $error("CRC byte count out of range");

endmodule

// File: rtl/rtcm3_out_stage.sv
// ----------------------------------------------------------------------------
// rtcm3_out_stage
// Output register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rtcm3_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtcm3_pkg::emit_t   emit_i,
  output logic               out_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtcm3_pkg::result_t res_o
);

  logic               valid_q;
  rtcm3_pkg::result_t res_q;

  // Room when empty or the held word leaves this cycle
  assign out_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.emit) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.emit) begin
      res_q <= emit_i.res;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.emit |-> !(valid_q && out_stall_i))
    else $error("result word overwritten while stalled");

endmodule

// File: rtl/rtcm3_frame_deframer_crc24q.sv
// ----------------------------------------------------------------------------
// rtcm3_frame_deframer_crc24q
// RTCM3 frame deframer: finds frames, checks CRC-24Q, reports message info.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle, set by the parser stage (8-bit
//   CRC-24Q step and phase state machine); the input stalls while the last
//   CRC byte of a frame waits for room in the output register. The result
//   word is registered in the output register as the parser takes that byte.
// Reset: asynchronous, active low; the parser returns to preamble search and
//   both word registers empty.
// ----------------------------------------------------------------------------
module rtcm3_frame_deframer_crc24q (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] message_number_o,
  output logic [9:0]  payload_length_o,
  output logic        crc_ok_o,
  output logic [23:0] computed_crc_o
);

  rtcm3_pkg::in_word_t in_word;
  rtcm3_pkg::emit_t    emit;
  rtcm3_pkg::result_t  res;
  logic                take;
  logic                out_ready;

  rtcm3_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .take_i      (take),
    .word_o      (in_word)
  );

  rtcm3_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (in_word),
    .out_ready_i (out_ready),
    .take_o      (take),
    .emit_o      (emit)
  );

  rtcm3_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign message_number_o = res.message_number;
  assign payload_length_o = res.payload_length;
  assign crc_ok_o         = res.crc_ok;
  assign computed_crc_o   = res.computed_crc;

endmodule

// File: dv/tb_rtcm3_frame_deframer_crc24q.sv
// ----------------------------------------------------------------------------
// tb_rtcm3_frame_deframer_crc24q
// Drives RTCM3 byte streams into the deframer and checks every result word
// against an in-bench deframer with its own CRC-24Q, under random idling,
// random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rtcm3_frame_deframer_crc24q;

  localparam int QuietLimit  = 2000;  // cycles with no word moving on either side
  localparam int HoldCycles  = 300;   // long receiver hold-off
  localparam int DrainCycles = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [11:0] message_number_o;
  logic [9:0]  payload_length_o;
  logic        crc_ok_o;
  logic [23:0] computed_crc_o;

  rtcm3_frame_deframer_crc24q u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .message_number_o (message_number_o),
    .payload_length_o (payload_length_o),
    .crc_ok_o         (crc_ok_o),
    .computed_crc_o   (computed_crc_o)
  );

  always #5 clk_i = ~clk_i;

  // Deframer state mirrored by the bench
  rtcm3_pkg::phase_e pr_phase = rtcm3_pkg::PH_SEARCH;
  logic [9:0]  pr_count = '0;
  logic [9:0]  pr_len   = '0;
  logic [23:0] pr_crc   = '0;
  logic [23:0] pr_rx    = '0;
  logic [11:0] pr_msg   = '0;

  rtcm3_pkg::result_t frame_results[$];  // results still owed by the block
  logic [7:0]  payload_q[$];      // payload of the next frame to build
  int          errors         = 0;
  int          bytes_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_trig      = 1'b0;
  bit          hold_seen      = 1'b0;
  int          hold_cnt       = 0;
  int          quiet_cycles   = 0;

  // CRC-24Q, one byte msb first, with the full 25-bit polynomial
  function automatic logic [23:0] crc24q_next(input logic [23:0] c, input logic [7:0] b);
    logic [24:0] acc;
    acc = {1'b0, c ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      acc = acc << 1;
      if (acc[24]) begin
        acc = acc ^ 25'h1864CFB;
      end
    end
    return acc[23:0];
  endfunction

  // Message number comes from the first two bytes after the header
  function automatic void take_msg_byte(input int pos, input logic [7:0] b);
    if (pos == 0) begin
      pr_msg = {b, 4'h0};
    end else if (pos == 1) begin
      pr_msg[3:0] = b[7:4];
    end
  endfunction

  // Advance the mirrored deframer by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    rtcm3_pkg::result_t r;
    case (pr_phase)
      rtcm3_pkg::PH_LEN_HI: begin
        pr_len   = {b[1:0], 8'h00};
        pr_crc   = crc24q_next(pr_crc, b);
        pr_phase = rtcm3_pkg::PH_LEN_LO;
      end
      rtcm3_pkg::PH_LEN_LO: begin
        pr_len   = pr_len | {2'b00, b};
        pr_crc   = crc24q_next(pr_crc, b);
        pr_count = '0;
        pr_rx    = '0;
        pr_phase = (pr_len == 10'd0) ? rtcm3_pkg::PH_CRC : rtcm3_pkg::PH_PAYLOAD;
      end
      rtcm3_pkg::PH_PAYLOAD: begin
        take_msg_byte(int'(pr_count), b);
        pr_crc   = crc24q_next(pr_crc, b);
        pr_count = pr_count + 10'd1;
        if (pr_count == pr_len) begin
          pr_count = '0;
          pr_phase = rtcm3_pkg::PH_CRC;
        end
      end
      rtcm3_pkg::PH_CRC: begin
        // short frames take the message number from CRC bytes
        take_msg_byte(int'(pr_len) + int'(pr_count), b);
        pr_rx    = {pr_rx[15:0], b};
        pr_count = pr_count + 10'd1;
        if (pr_count == 10'd3) begin
          r.message_number = pr_msg;
          r.payload_length = pr_len;
          r.crc_ok         = (pr_crc == pr_rx);
          r.computed_crc   = pr_crc;
          frame_results.push_back(r);
          pr_phase = rtcm3_pkg::PH_SEARCH;
          pr_count = '0;
        end
      end
      default: begin
        if (b == rtcm3_pkg::Preamble) begin
          pr_crc   = crc24q_next(24'h000000, b);
          pr_len   = '0;
          pr_count = '0;
          pr_rx    = '0;
          pr_msg   = '0;
          pr_phase = rtcm3_pkg::PH_LEN_HI;
        end else begin
          pr_phase = rtcm3_pkg::PH_SEARCH;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    errors++;
    $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
  endtask

  // Offer one byte word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Build a frame around payload_q; crc_flip corrupts the CRC, keep truncates
  task automatic send_frame(input logic [5:0] rsv, input logic [23:0] crc_flip,
                            input int keep);
    logic [7:0]  fb[$];
    logic [23:0] c;
    logic [9:0]  len10;
    len10 = 10'(payload_q.size());
    fb = {};
    fb.push_back(rtcm3_pkg::Preamble);
    fb.push_back({rsv, len10[9:8]});
    fb.push_back(len10[7:0]);
    foreach (payload_q[i]) fb.push_back(payload_q[i]);
    c = '0;
    foreach (fb[i]) c = crc24q_next(c, fb[i]);
    c = c ^ crc_flip;
    fb.push_back(c[23:16]);
    fb.push_back(c[15:8]);
    fb.push_back(c[7:0]);
    for (int i = 0; i < fb.size() && i < keep; i++) begin
      send_byte(fb[i]);
    end
  endtask

  task automatic fill_payload(input int len);
    payload_q = {};
    repeat (len) payload_q.push_back(8'($urandom_range(255)));
  endtask

  // Feed zero bytes until the deframer is back in preamble search
  task automatic resync();
    while (pr_phase != rtcm3_pkg::PH_SEARCH) send_byte(8'h00);
  endtask

  // Short frames, reserved bits, bad CRC, preamble inside a payload
  task automatic test_directed();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    resync();
    payload_q = {};
    send_frame(6'h00, 24'h000000, 32'h7fffffff);
    payload_q = {8'hFF};
    send_frame(6'h3F, 24'h000001, 32'h7fffffff);
    send_byte(8'h00);
    send_byte(8'hFF);
    payload_q = {8'hD3, 8'h5F};
    send_frame(6'h00, 24'h000000, 32'h7fffffff);
  endtask

  // Largest payload length
  task automatic test_max_length();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    resync();
    fill_payload(1023);
    send_frame(6'($urandom_range(63)), 24'h000000, 32'h7fffffff);
  endtask

  // Mostly well-formed frames with random content, some noise and broken ones
  task automatic test_random(input int n_bytes, input int idle_pct, input int stall_pct);
    int          start;
    int          kind;
    int          len;
    logic [23:0] flip;
    logic [5:0]  rsv;
    int          keep;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else begin
        len  = ($urandom_range(39) == 0) ? $urandom_range(200) : $urandom_range(24);
        flip = ($urandom_range(7) == 0) ? 24'($urandom_range(1, 24'hFFFFFF)) : 24'h0;
        rsv  = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'h00;
        keep = ($urandom_range(19) == 0) ? $urandom_range(1, len + 5) : 32'h7fffffff;
        fill_payload(len);
        send_frame(rsv, flip, keep);
      end
    end
  endtask

  // Long output hold-off while zero-length frames keep coming in
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    resync();
    hold_trig = ~hold_trig;
    repeat (40) begin
      fill_payload(0);
      send_frame(6'h00, 24'h000000, 32'h7fffffff);
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_cnt  = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  task automatic check_result();
    rtcm3_pkg::result_t e;
    if (frame_results.size() == 0) begin
      report_mismatch("result with none expected, crc", 32'(computed_crc_o), 32'h0);
    end else begin
      e = frame_results.pop_front();
      if (message_number_o !== e.message_number)
        report_mismatch("message_number", 32'(message_number_o), 32'(e.message_number));
      if (payload_length_o !== e.payload_length)
        report_mismatch("payload_length", 32'(payload_length_o), 32'(e.payload_length));
      if (crc_ok_o !== e.crc_ok)
        report_mismatch("crc_ok", 32'(crc_ok_o), 32'(e.crc_ok));
      if (computed_crc_o !== e.computed_crc)
        report_mismatch("computed_crc", 32'(computed_crc_o), 32'(e.computed_crc));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result();
    end
  end

  // Watchdog: ends the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("rtcm3_frame_deframer_crc24q: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_max_length();
    test_random(200, 0, 0);
    test_random(200, 55, 0);
    test_random(200, 0, 55);
    test_random(200, 28, 28);
    test_backpressure();
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("rtcm3_frame_deframer_crc24q: match");
    end else begin
      $display("rtcm3_frame_deframer_crc24q: mismatch");
    end
    $finish;
  end

endmodule
